// ===== rtl/core/fdi_pkg.sv =====
// Shared types, constants and helpers of the field deinterlacer.
package fdi_pkg;

    // Fixed field widths
    localparam int CHANNEL_BITS = 8;
    localparam int MODE_W       = 3;
    localparam int SIZE_W       = 11;
    localparam int CFG_ADDR_W   = 4;
    localparam int CFG_DATA_W   = 32;
    localparam int REG_IDX_W    = 2;

    // Defaults for the top-level size parameters
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_MODE         = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

    // Mode codes; unused codes behave as odd double
    localparam logic [MODE_W-1:0] MODE_EVEN    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ODD     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_AVERAGE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SWAP    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_WEAVE   = 3'd4;

    // Reset values of the registers
    localparam logic [MODE_W-1:0] MODE_RST         = MODE_ODD;
    localparam logic [SIZE_W-1:0] FRAME_WIDTH_RST  = 11'd720;
    localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RST = 11'd480;

    // Classification of an accepted pixel
    localparam int KIND_W = 2;
    localparam logic [KIND_W-1:0] KIND_UPPER  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOWER  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SINGLE = 2'd2;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] pixel_red;
        logic [CHANNEL_BITS-1:0] pixel_green;
        logic [CHANNEL_BITS-1:0] pixel_blue;
        logic [CHANNEL_BITS-1:0] pixel_alpha;
    } pixel_t;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] top_red;
        logic [CHANNEL_BITS-1:0] top_green;
        logic [CHANNEL_BITS-1:0] top_blue;
        logic [CHANNEL_BITS-1:0] top_alpha;
        logic [CHANNEL_BITS-1:0] bottom_red;
        logic [CHANNEL_BITS-1:0] bottom_green;
        logic [CHANNEL_BITS-1:0] bottom_blue;
        logic [CHANNEL_BITS-1:0] bottom_alpha;
        logic                    single_row;
        logic                    end_of_frame;
    } result_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [SIZE_W-1:0] frame_width;
        logic [SIZE_W-1:0] frame_height;
    } cfg_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              eof;
        pixel_t            px;
    } item_ctl_t;

    // Per-channel truncated average
    function automatic pixel_t px_avg(pixel_t a, pixel_t b);
        logic [CHANNEL_BITS:0] s_r;
        logic [CHANNEL_BITS:0] s_g;
        logic [CHANNEL_BITS:0] s_b;
        logic [CHANNEL_BITS:0] s_a;
        pixel_t                r;
        s_r = {1'b0, a.pixel_red}   + {1'b0, b.pixel_red};
        s_g = {1'b0, a.pixel_green} + {1'b0, b.pixel_green};
        s_b = {1'b0, a.pixel_blue}  + {1'b0, b.pixel_blue};
        s_a = {1'b0, a.pixel_alpha} + {1'b0, b.pixel_alpha};
        r.pixel_red   = s_r[CHANNEL_BITS:1];
        r.pixel_green = s_g[CHANNEL_BITS:1];
        r.pixel_blue  = s_b[CHANNEL_BITS:1];
        r.pixel_alpha = s_a[CHANNEL_BITS:1];
        return r;
    endfunction

endpackage

// ===== rtl/core/fdi_fifo.sv =====
// Small register queue used between the pipeline parts and for the results.
module fdi_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill count beyond depth");
`endif

endmodule

// ===== rtl/core/fdi_cfg.sv =====
// Configuration register file behind the APB-style port.
module fdi_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fdi_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [fdi_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [fdi_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready,
    output fdi_pkg::cfg_t                   cfg
);

    fdi_pkg::cfg_t                     cfg_reg;
    logic [fdi_pkg::REG_IDX_W-1:0]     reg_idx;
    logic                              wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[fdi_pkg::CFG_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_comb
    begin
        unique case (reg_idx)
            fdi_pkg::REG_MODE:
                prdata = fdi_pkg::CFG_DATA_W'(cfg_reg.mode);
            fdi_pkg::REG_FRAME_WIDTH:
                prdata = fdi_pkg::CFG_DATA_W'(cfg_reg.frame_width);
            fdi_pkg::REG_FRAME_HEIGHT:
                prdata = fdi_pkg::CFG_DATA_W'(cfg_reg.frame_height);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode         <= fdi_pkg::MODE_RST;
            cfg_reg.frame_width  <= fdi_pkg::FRAME_WIDTH_RST;
            cfg_reg.frame_height <= fdi_pkg::FRAME_HEIGHT_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                fdi_pkg::REG_MODE:
                    cfg_reg.mode <= pwdata[fdi_pkg::MODE_W-1:0];
                fdi_pkg::REG_FRAME_WIDTH:
                    cfg_reg.frame_width <= pwdata[fdi_pkg::SIZE_W-1:0];
                fdi_pkg::REG_FRAME_HEIGHT:
                    cfg_reg.frame_height <= pwdata[fdi_pkg::SIZE_W-1:0];
                default:
                    ;
            endcase
        end
    end

endmodule

// ===== rtl/core/fdi_front.sv =====
// Front part: raster counters and pixel classification.
module fdi_front #(
    parameter int MAX_WIDTH  = fdi_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = fdi_pkg::MAX_HEIGHT_DEF,
    localparam int COL_W     = $clog2(MAX_WIDTH),
    localparam int ROW_W     = $clog2(MAX_HEIGHT),
    localparam int PAIR_W    = ROW_W - 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  fdi_pkg::cfg_t       cfg,
    input  logic                accept,
    input  fdi_pkg::pixel_t     pixel,
    output fdi_pkg::item_ctl_t  item_ctl,
    output logic [COL_W-1:0]    item_col,
    output logic [PAIR_W-1:0]   item_pair
);

    localparam int WW    = COL_W + 1;
    localparam int HW    = ROW_W + 1;
    localparam int CMPW_W = (fdi_pkg::SIZE_W > WW) ? fdi_pkg::SIZE_W : WW;
    localparam int CMPH_W = (fdi_pkg::SIZE_W > HW) ? fdi_pkg::SIZE_W : HW;

    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [CMPW_W-1:0] fw_ext;
    logic [CMPH_W-1:0] fh_ext;
    logic [WW-1:0]     w_eff;
    logic [HW-1:0]     h_eff;
    logic [COL_W-1:0]  w_last;
    logic [ROW_W-1:0]  h_last;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic              last_col;
    logic              last_row;

    // Saturate the frame size into 1..MAX
    always_comb
    begin
        fw_ext = CMPW_W'(cfg.frame_width);
        fh_ext = CMPH_W'(cfg.frame_height);
        if (fw_ext == '0)
            w_eff = WW'(1);
        else if (fw_ext > CMPW_W'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = fw_ext[WW-1:0];
        if (fh_ext == '0)
            h_eff = HW'(1);
        else if (fh_ext > CMPH_W'(MAX_HEIGHT))
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = fh_ext[HW-1:0];
    end

    assign w_last   = COL_W'(w_eff - 1'b1);
    assign h_last   = ROW_W'(h_eff - 1'b1);
    // A counter at or past the last position counts as the last position
    assign col      = ({1'b0, col_reg} < w_eff) ? col_reg : w_last;
    assign row      = ({1'b0, row_reg} < h_eff) ? row_reg : h_last;
    assign last_col = (col == w_last);
    assign last_row = (row == h_last);

    always_comb
    begin
        item_ctl.px  = pixel;
        item_ctl.eof = last_col && last_row;
        if (row[0])
            item_ctl.kind = fdi_pkg::KIND_LOWER;
        else if (last_row)
            item_ctl.kind = fdi_pkg::KIND_SINGLE;
        else
            item_ctl.kind = fdi_pkg::KIND_UPPER;
    end

    assign item_col  = col;
    assign item_pair = row[ROW_W-1:1];

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row + 1'b1;
            end
            else
            begin
                col_next = col + 1'b1;
                row_next = row;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

`ifndef SYNTHESIS
    a_eof_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item_ctl.eof |=> col_reg == '0 && row_reg == '0)
        else $error("frame end did not wrap the raster counters");
`endif

endmodule

// ===== rtl/core/fdi_back.sv =====
// Back part: line buffer, field store and result formation.
module fdi_back #(
    parameter int MAX_WIDTH  = fdi_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = fdi_pkg::MAX_HEIGHT_DEF,
    localparam int COL_W     = $clog2(MAX_WIDTH),
    localparam int ROW_W     = $clog2(MAX_HEIGHT),
    localparam int PAIR_W    = ROW_W - 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  fdi_pkg::cfg_t       cfg,
    input  logic                mid_empty,
    input  fdi_pkg::item_ctl_t  item_ctl,
    input  logic [COL_W-1:0]    item_col,
    input  logic [PAIR_W-1:0]   item_pair,
    output logic                mid_pop,
    input  logic                out_full,
    output logic                out_push,
    output fdi_pkg::result_t    out_data,
    output logic                clearing
);

    localparam int PAIR_ROWS   = (MAX_HEIGHT + 1) / 2;
    localparam int STORE_DEPTH = PAIR_ROWS * (2 ** COL_W);
    localparam int FS_AW       = PAIR_W + COL_W;

    fdi_pkg::pixel_t  lb_mem [MAX_WIDTH];
    fdi_pkg::pixel_t  fs_mem [STORE_DEPTH];
    fdi_pkg::pixel_t  lb_rd_reg;
    fdi_pkg::pixel_t  fs_rd_reg;
    fdi_pkg::pixel_t  b_px_reg;
    logic             b_valid_reg;
    logic             b_single_reg;
    logic             b_eof_reg;
    logic             clearing_reg, clearing_next;
    logic [FS_AW-1:0] clr_addr_reg, clr_addr_next;
    logic [FS_AW-1:0] fs_addr;
    logic             b_ready;
    logic             is_upper;
    logic             lb_wr;
    logic             lo_rd;
    fdi_pkg::pixel_t  top_px;
    fdi_pkg::pixel_t  bot_px;

    assign fs_addr  = {item_pair, item_col};
    assign is_upper = (item_ctl.kind == fdi_pkg::KIND_UPPER);
    assign b_ready  = !b_valid_reg || !out_full;
    // Upper-row beats only touch the line buffer, so they need no room downstream
    assign mid_pop  = !mid_empty && !clearing_reg && (is_upper || b_ready);
    assign lb_wr    = mid_pop && is_upper;
    assign lo_rd    = mid_pop && (item_ctl.kind == fdi_pkg::KIND_LOWER);
    assign clearing = clearing_reg;

    // Zero sweep over the field store after reset
    always_comb
    begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg)
        begin
            if (clr_addr_reg == FS_AW'(STORE_DEPTH - 1))
                clearing_next = 1'b0;
            else
                clr_addr_next = clr_addr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
            b_valid_reg  <= 1'b0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
            if (b_ready)
                b_valid_reg <= mid_pop && !is_upper;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready)
        begin
            b_px_reg     <= item_ctl.px;
            b_single_reg <= (item_ctl.kind == fdi_pkg::KIND_SINGLE);
            b_eof_reg    <= item_ctl.eof;
        end
    end

    always_ff @(posedge clk)
    begin
        if (lb_wr)
            lb_mem[item_col] <= item_ctl.px;
        if (lo_rd)
            lb_rd_reg <= lb_mem[item_col];
    end

    // Read-first: weave sees the previous frame before this beat overwrites it
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
            fs_mem[clr_addr_reg] <= '0;
        else if (lo_rd)
            fs_mem[fs_addr] <= item_ctl.px;
        if (lo_rd)
            fs_rd_reg <= fs_mem[fs_addr];
    end

    always_comb
    begin
        unique case (cfg.mode)
            fdi_pkg::MODE_EVEN:
            begin
                top_px = lb_rd_reg;
                bot_px = lb_rd_reg;
            end
            fdi_pkg::MODE_AVERAGE:
            begin
                top_px = fdi_pkg::px_avg(lb_rd_reg, b_px_reg);
                bot_px = top_px;
            end
            fdi_pkg::MODE_SWAP:
            begin
                top_px = b_px_reg;
                bot_px = lb_rd_reg;
            end
            fdi_pkg::MODE_WEAVE:
            begin
                top_px = lb_rd_reg;
                bot_px = fs_rd_reg;
            end
            default:
            begin
                top_px = b_px_reg;
                bot_px = b_px_reg;
            end
        endcase
        if (b_single_reg)
        begin
            top_px = b_px_reg;
            bot_px = '0;
        end
        out_data.top_red      = top_px.pixel_red;
        out_data.top_green    = top_px.pixel_green;
        out_data.top_blue     = top_px.pixel_blue;
        out_data.top_alpha    = top_px.pixel_alpha;
        out_data.bottom_red   = bot_px.pixel_red;
        out_data.bottom_green = bot_px.pixel_green;
        out_data.bottom_blue  = bot_px.pixel_blue;
        out_data.bottom_alpha = bot_px.pixel_alpha;
        out_data.single_row   = b_single_reg;
        out_data.end_of_frame = b_eof_reg;
    end

    assign out_push = b_valid_reg && !out_full;

`ifndef SYNTHESIS
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> mid_empty && !b_valid_reg)
        else $error("work in flight during field store clear");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && out_full |=> b_valid_reg && $stable(b_px_reg)
            && $stable(lb_rd_reg) && $stable(fs_rd_reg))
        else $error("result stage changed while stalled");
`endif

endmodule

// ===== rtl/core/field_deinterlacer_core.sv =====
// Top level of the field deinterlacer: front, queues, back and register file.
//
//   channel   direction  handshake              payload
//   -------   ---------  ---------------------  ------------------------------
//   config    in/out     psel penable pwrite    paddr pwdata prdata (pready=1)
//   pixel     in         push / full            pixel (pixel_t, RGBA)
//   result    out        pop / empty            result (result_t, top+bottom)
//
// Flow: one pixel beat per clock sustained while full stays low; a result reaches
// the result ports through the front queue, the memory read into the result
// stage, then the result queue.
// Reset: full stays high for STORE_DEPTH clocks (524288 at default sizes)
// while the field store is swept to zero, one entry per clock.
// Stalls: a four-entry queue parts the front from the back and a two-entry
// queue holds results, so a held pop backs up into full only after both fill.
module field_deinterlacer_core #(
    parameter int MAX_WIDTH  = fdi_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = fdi_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fdi_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [fdi_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [fdi_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready,
    // pixel beats
    input  logic                            push,
    output logic                            full,
    input  fdi_pkg::pixel_t                 pixel,
    // result beats
    output logic                            empty,
    input  logic                            pop,
    output fdi_pkg::result_t                result
);

    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT);
    localparam int PAIR_W    = ROW_W - 1;
    localparam int CTL_W     = $bits(fdi_pkg::item_ctl_t);
    localparam int ITEM_W    = CTL_W + COL_W + PAIR_W;
    localparam int RES_W     = $bits(fdi_pkg::result_t);
    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 2;

    fdi_pkg::cfg_t      cfg;
    fdi_pkg::item_ctl_t front_ctl;
    logic [COL_W-1:0]   front_col;
    logic [PAIR_W-1:0]  front_pair;
    fdi_pkg::item_ctl_t back_ctl;
    logic [COL_W-1:0]   back_col;
    logic [PAIR_W-1:0]  back_pair;
    logic [ITEM_W-1:0]  mid_wdata;
    logic [ITEM_W-1:0]  mid_rdata;
    logic               mid_full;
    logic               mid_empty;
    logic               mid_pop;
    logic               accept;
    logic               clearing;
    logic               out_full;
    logic               out_push;
    fdi_pkg::result_t   out_data;
    logic [RES_W-1:0]   out_rdata;

    // Hold off pixel beats while the field store clear runs
    assign full   = mid_full || clearing;
    assign accept = push && !full;

    fdi_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Front: advance the raster counters and tag each beat
    fdi_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .accept    (accept),
        .pixel     (pixel),
        .item_ctl  (front_ctl),
        .item_col  (front_col),
        .item_pair (front_pair)
    );

    assign mid_wdata = {front_ctl, front_col, front_pair};

    fdi_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (accept),
        .wdata (mid_wdata),
        .full  (mid_full),
        .pop   (mid_pop),
        .rdata (mid_rdata),
        .empty (mid_empty)
    );

    assign back_ctl  = mid_rdata[ITEM_W-1 -: CTL_W];
    assign back_col  = mid_rdata[PAIR_W +: COL_W];
    assign back_pair = mid_rdata[PAIR_W-1:0];

    // Back: memory accesses and result formation
    fdi_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .mid_empty (mid_empty),
        .item_ctl  (back_ctl),
        .item_col  (back_col),
        .item_pair (back_pair),
        .mid_pop   (mid_pop),
        .out_full  (out_full),
        .out_push  (out_push),
        .out_data  (out_data),
        .clearing  (clearing)
    );

    fdi_fifo #(
        .WIDTH (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_data),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_rdata),
        .empty (empty)
    );

    assign result = out_rdata;

endmodule

// ===== tb/sv/tb_field_deinterlacer_core.sv =====
// Self-checking testbench for the field deinterlacer: directed and random pixel beats.
module tb_field_deinterlacer_core;

    // Geometry of the block as built with default parameters
    localparam int MAX_W        = fdi_pkg::MAX_WIDTH_DEF;
    localparam int MAX_H        = fdi_pkg::MAX_HEIGHT_DEF;
    // The field store is swept one entry per clock after reset; full stays high
    // for that long, so the watchdog must outlast it with margin.
    localparam int STORE_SWEEP  = ((MAX_H + 1) / 2) * MAX_W;
    localparam int STALL_LIMIT  = 4 * STORE_SWEEP + 4096;
    // Upper-row beats give no result, so let the front queue and result stage
    // empty out before touching a register.
    localparam int SETTLE_CYCLES = 24;
    localparam int DRAIN_CYCLES  = 32;
    localparam int REPORT_CAP    = 10;
    localparam int RANDOM_BEATS  = 500;

    // Codes 5 to 7 are unused and act as odd double
    localparam logic [fdi_pkg::MODE_W-1:0] MODE_SPARE = 3'd7;
    localparam logic [fdi_pkg::MODE_W-1:0] DOUBLE_MODES [4] = '{fdi_pkg::MODE_ODD,
                                                                fdi_pkg::MODE_AVERAGE,
                                                                fdi_pkg::MODE_SWAP,
                                                                MODE_SPARE};

    // Channel extremes for a 3x3 frame: two paired rows and one unpaired row
    localparam logic [31:0] CORNER [9] = '{
        32'hFFFF_FFFF, 32'h0000_0000, 32'hA55A_C33C,
        32'h0000_0000, 32'hFFFF_FFFF, 32'h5AA5_3CC3,
        32'hFF00_FF00, 32'h00FF_00FF, 32'h1234_5678
    };
    // Upper/lower pair whose channel sums are all odd
    localparam logic [31:0] UPPER_MIX = 32'hFF00_817E;
    localparam logic [31:0] LOWER_MIX = 32'h00FF_807F;

    // ------------------------------------------------------------------
    // Predictor of the row pairing and the per-mode output pixels. Holds its
    // own copy of the registers, counters, line buffer and field store, and a
    // queue of the pairs still owed by the block.
    // ------------------------------------------------------------------
    class pair_checker;
        logic [fdi_pkg::MODE_W-1:0] mode;
        logic [fdi_pkg::SIZE_W-1:0] frame_width;
        logic [fdi_pkg::SIZE_W-1:0] frame_height;
        int unsigned                column;
        int unsigned                row;
        fdi_pkg::pixel_t            line_copy [MAX_W];
        fdi_pkg::pixel_t            field_copy [int unsigned];
        fdi_pkg::result_t           pairs_due [$];
        int                         beats;
        int                         pairs_seen;
        int                         faults;

        function new();
            mode         = fdi_pkg::MODE_RST;
            frame_width  = fdi_pkg::FRAME_WIDTH_RST;
            frame_height = fdi_pkg::FRAME_HEIGHT_RST;
            column       = 0;
            row          = 0;
            beats        = 0;
            pairs_seen   = 0;
            faults       = 0;
        endfunction

        function void write_reg(logic [fdi_pkg::REG_IDX_W-1:0] idx,
                                logic [fdi_pkg::CFG_DATA_W-1:0] value);
            case (idx)
                fdi_pkg::REG_MODE:         mode = value[fdi_pkg::MODE_W-1:0];
                fdi_pkg::REG_FRAME_WIDTH:  frame_width = value[fdi_pkg::SIZE_W-1:0];
                fdi_pkg::REG_FRAME_HEIGHT: frame_height = value[fdi_pkg::SIZE_W-1:0];
                default: ;
            endcase
        endfunction

        // Saturate a size register to 1..hi
        static function int unsigned fit(logic [fdi_pkg::SIZE_W-1:0] v, int unsigned hi);
            if (v == 0)
                return 1;
            if (v > hi)
                return hi;
            return 32'(v);
        endfunction

        static function logic [fdi_pkg::CHANNEL_BITS-1:0] mean(
            logic [fdi_pkg::CHANNEL_BITS-1:0] a,
            logic [fdi_pkg::CHANNEL_BITS-1:0] b);
            logic [fdi_pkg::CHANNEL_BITS:0] sum;
            sum = {1'b0, a} + {1'b0, b};
            return sum[fdi_pkg::CHANNEL_BITS:1];
        endfunction

        static function string show(fdi_pkg::result_t v);
            return $sformatf("top %h_%h_%h_%h bottom %h_%h_%h_%h single %b eof %b",
                             v.top_red, v.top_green, v.top_blue, v.top_alpha,
                             v.bottom_red, v.bottom_green, v.bottom_blue, v.bottom_alpha,
                             v.single_row, v.end_of_frame);
        endfunction

        function bit frame_open();
            return column != 0 || row != 0;
        endfunction

        // Take one accepted pixel beat; queue the pair it completes, if any
        function void note_pixel(fdi_pkg::pixel_t px);
            int unsigned      w;
            int unsigned      h;
            int unsigned      c;
            int unsigned      r;
            int unsigned      slot;
            bit               last_col;
            bit               last_row;
            fdi_pkg::pixel_t  upper;
            fdi_pkg::pixel_t  earlier;
            fdi_pkg::pixel_t  top;
            fdi_pkg::pixel_t  bottom;
            fdi_pkg::result_t pair;
            w = fit(frame_width, MAX_W);
            h = fit(frame_height, MAX_H);
            // a counter past a shrunken size sits at the last position
            c = (column < w) ? column : w - 1;
            r = (row < h) ? row : h - 1;
            last_col = (c + 1 >= w);
            last_row = (r + 1 >= h);
            beats++;
            if (r % 2 == 0 && r + 1 < h)
            begin
                line_copy[c] = px;
            end
            else if (r % 2 == 0)
            begin
                // unpaired final row passes through on top only
                pair = {px, fdi_pkg::pixel_t'(0), 1'b1, last_col && last_row};
                pairs_due.push_back(pair);
            end
            else
            begin
                slot    = (r / 2) * MAX_W + c;
                upper   = line_copy[c];
                earlier = field_copy.exists(slot) ? field_copy[slot] : fdi_pkg::pixel_t'(0);
                case (mode)
                    fdi_pkg::MODE_EVEN:
                    begin
                        top    = upper;
                        bottom = upper;
                    end
                    fdi_pkg::MODE_AVERAGE:
                    begin
                        top.pixel_red   = mean(upper.pixel_red, px.pixel_red);
                        top.pixel_green = mean(upper.pixel_green, px.pixel_green);
                        top.pixel_blue  = mean(upper.pixel_blue, px.pixel_blue);
                        top.pixel_alpha = mean(upper.pixel_alpha, px.pixel_alpha);
                        bottom          = top;
                    end
                    fdi_pkg::MODE_SWAP:
                    begin
                        top    = px;
                        bottom = upper;
                    end
                    fdi_pkg::MODE_WEAVE:
                    begin
                        top    = upper;
                        bottom = earlier;
                    end
                    default:
                    begin
                        top    = px;
                        bottom = px;
                    end
                endcase
                // every mode keeps the lower field for the next frame's weave
                field_copy[slot] = px;
                pair = {top, bottom, 1'b0, last_col && last_row};
                pairs_due.push_back(pair);
            end
            if (last_col)
            begin
                column = 0;
                row    = last_row ? 0 : r + 1;
            end
            else
            begin
                column = c + 1;
                row    = r;
            end
        endfunction

        // Compare one accepted result beat with the oldest pair owed
        function void check_pair(fdi_pkg::result_t got);
            fdi_pkg::result_t want;
            pairs_seen++;
            if (pairs_due.size() == 0)
            begin
                faults++;
                if (faults <= REPORT_CAP)
                    $display("result %0d arrived with nothing owed: %s", pairs_seen, show(got));
                return;
            end
            want = pairs_due.pop_front();
            if (got !== want)
            begin
                faults++;
                if (faults <= REPORT_CAP)
                begin
                    $display("result %0d mismatch", pairs_seen);
                    $display("  expected %s", show(want));
                    $display("  actual   %s", show(got));
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, block inputs (all known from time zero) and the block itself
    // ------------------------------------------------------------------
    logic                           clk     = 1'b0;
    logic                           rst_n   = 1'b0;
    logic                           psel    = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite  = 1'b0;
    logic [fdi_pkg::CFG_ADDR_W-1:0] paddr   = '0;
    logic [fdi_pkg::CFG_DATA_W-1:0] pwdata  = '0;
    logic [fdi_pkg::CFG_DATA_W-1:0] prdata;
    logic                           pready;
    logic                           push    = 1'b0;
    logic                           full;
    fdi_pkg::pixel_t                pixel   = '0;
    logic                           empty;
    logic                           pop     = 1'b0;
    fdi_pkg::result_t               result;

    pair_checker board;
    bit          steady     = 1'b0;   // set for stretches with no idling
    int          pop_wait   = 0;
    int          idle_cycles = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    field_deinterlacer_core uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .push    (push),
        .full    (full),
        .pixel   (pixel),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    // Idle length for either side: mostly none or short, now and then long
    function automatic int gap_length();
        int roll;
        if (steady)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Channels lean toward the extremes so every bit sees both values
    function automatic fdi_pkg::pixel_t random_pixel();
        logic [fdi_pkg::CHANNEL_BITS-1:0] ch [4];
        foreach (ch[i])
        begin
            case ($urandom_range(0, 9))
                0:       ch[i] = '0;
                1:       ch[i] = '1;
                default: ch[i] = fdi_pkg::CHANNEL_BITS'($urandom_range(0, 255));
            endcase
        end
        return {ch[0], ch[1], ch[2], ch[3]};
    endfunction

    // ------------------------------------------------------------------
    // Result side: check each accepted beat, then pick the next pop level.
    // Sampling at the edge sees the values from before the edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            board.check_pair(result);
        if (pop_wait > 0)
        begin
            pop      <= 1'b0;
            pop_wait <= pop_wait - 1;
        end
        else
        begin
            pop      <= 1'b1;
            pop_wait <= gap_length();
        end
    end

    // Watchdog: count edges at which no beat moves on either side
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Pixel side and register port
    // ------------------------------------------------------------------

    // Offer one pixel beat after an optional gap; hold it until accepted
    task automatic send_pixel(input fdi_pkg::pixel_t px);
        int gap;
        gap = gap_length();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push  <= 1'b1;
        pixel <= px;
        @(posedge clk);
        while (full) @(posedge clk);
        board.note_pixel(px);
    endtask

    task automatic run_pixels(input int count);
        repeat (count) send_pixel(random_pixel());
    endtask

    // Drop push, wait for every owed pair, then let in-flight upper beats drain
    task automatic settle();
        push <= 1'b0;
        while (board.pairs_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Setup then access; leaves psel high so writes can run back to back
    task automatic apb_write(input logic [fdi_pkg::REG_IDX_W-1:0] idx,
                             input logic [fdi_pkg::CFG_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        board.write_reg(idx, value);
    endtask

    task automatic apb_release();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(input logic [fdi_pkg::MODE_W-1:0] m, input int w, input int h);
        settle();
        apb_write(fdi_pkg::REG_MODE, fdi_pkg::CFG_DATA_W'(m));
        apb_write(fdi_pkg::REG_FRAME_WIDTH, fdi_pkg::CFG_DATA_W'(w));
        apb_write(fdi_pkg::REG_FRAME_HEIGHT, fdi_pkg::CFG_DATA_W'(h));
        apb_release();
    endtask

    // Single register write, used to shrink a size in the middle of a frame
    task automatic set_reg(input logic [fdi_pkg::REG_IDX_W-1:0] idx, input int value);
        settle();
        apb_write(idx, fdi_pkg::CFG_DATA_W'(value));
        apb_release();
    endtask

    // Advance to the next frame start so a later size change is safe
    task automatic finish_frame();
        while (board.frame_open()) send_pixel(random_pixel());
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int                         target;
        int                         span;
        int                         w_eff;
        int                         h_eff;
        int                         cfg_w;
        int                         cfg_h;
        logic [fdi_pkg::MODE_W-1:0] cfg_mode;

        board = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Even double on a 3x3 frame: paired rows, then the unpaired row
        configure(fdi_pkg::MODE_EVEN, 3, 3);
        foreach (CORNER[i])
            send_pixel(fdi_pkg::pixel_t'(CORNER[i]));

        // One pair per remaining double mode, including an unused code
        foreach (DOUBLE_MODES[i])
        begin
            configure(DOUBLE_MODES[i], 1, 2);
            send_pixel(fdi_pkg::pixel_t'(UPPER_MIX));
            send_pixel(fdi_pkg::pixel_t'(LOWER_MIX));
        end

        // Weave: first pair reads a stored field, second reads a cleared entry
        configure(fdi_pkg::MODE_WEAVE, 1, 4);
        run_pixels(4);

        // Width above the maximum saturates (all size bits set); shrink it
        // mid-row to end the row
        configure(fdi_pkg::MODE_SWAP, 2047, 2);
        run_pixels(2);
        set_reg(fdi_pkg::REG_FRAME_WIDTH, 2);
        finish_frame();

        // Height above the maximum saturates; shrink it mid-frame
        configure(fdi_pkg::MODE_AVERAGE, 1, 2047);
        run_pixels(3);
        set_reg(fdi_pkg::REG_FRAME_HEIGHT, 2);
        finish_frame();

        // Zero sizes act as 1x1: every beat is an unpaired row and a frame end
        configure(fdi_pkg::MODE_EVEN, 0, 0);
        run_pixels(2);

        // Random phases: small frames, random mode, now and then a mid-frame shrink
        target = board.beats + RANDOM_BEATS;
        while (board.beats < target)
        begin
            steady   = ($urandom_range(0, 5) == 0);
            cfg_mode = fdi_pkg::MODE_W'($urandom_range(0, (1 << fdi_pkg::MODE_W) - 1));
            cfg_w    = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : $urandom_range(9, 24);
            cfg_h    = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 12);
            if ($urandom_range(0, 24) == 0)
                cfg_w = 0;
            if ($urandom_range(0, 24) == 0)
                cfg_h = 0;
            w_eff = (cfg_w == 0) ? 1 : cfg_w;
            h_eff = (cfg_h == 0) ? 1 : cfg_h;
            span  = w_eff * h_eff;
            configure(cfg_mode, cfg_w, cfg_h);
            if (span > 1 && $urandom_range(0, 3) == 0)
            begin
                run_pixels($urandom_range(1, span - 1));
                if ($urandom_range(0, 1) == 0)
                    set_reg(fdi_pkg::REG_FRAME_WIDTH, $urandom_range(1, w_eff));
                else
                    set_reg(fdi_pkg::REG_FRAME_HEIGHT, $urandom_range(1, h_eff));
                finish_frame();
            end
            else
            begin
                run_pixels(span * $urandom_range(1, 2));
            end
        end

        // Drain: wait for every owed pair, then watch for strays
        steady = 1'b0;
        push <= 1'b0;
        while (board.pairs_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.faults == 0 && board.pairs_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
